FILE: rtl/pcapdf_pkg.sv
`default_nettype none

package pcapdf_pkg;

    // Header sizes in bytes.
    localparam int unsigned GLOBAL_HDR_LEN = 24;
    localparam int unsigned RECORD_HDR_LEN = 16;
    localparam int unsigned HDR_IDX_W      = $clog2(GLOBAL_HDR_LEN);

    // Magic words as read little-endian from the first four bytes.
    localparam logic [31:0] MAGIC_SWAP_NS = 32'h4d3cb2a1;
    localparam logic [31:0] MAGIC_SWAP_US = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NAT_US  = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_NAT_NS  = 32'ha1b23c4d;

    localparam logic [15:0] VER_REQ_HI    = 16'd2;
    localparam logic [15:0] VER_REQ_LO    = 16'd4;
    localparam logic [31:0] NS_PER_US     = 32'd1000;

    // Input kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kinds.
    localparam logic [2:0] RK_FILE_HDR = 3'd0;
    localparam logic [2:0] RK_PKT_HDR  = 3'd1;
    localparam logic [2:0] RK_PAYLOAD  = 3'd2;
    localparam logic [2:0] RK_END      = 3'd3;
    localparam logic [2:0] RK_ERROR    = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
    localparam logic [2:0] ERR_OVER_SNAP   = 3'd3;
    localparam logic [2:0] ERR_TRUNC_GLOB  = 3'd4;
    localparam logic [2:0] ERR_TRUNC_REC   = 3'd5;
    localparam logic [2:0] ERR_TRUNC_PAY   = 3'd6;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_GLOBAL  = 4'b0001,
        PH_RECORD  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [2:0]  error_code;
        logic [31:0] link_type;
        logic [31:0] snap_len;
        logic        byte_swapped;
        logic        nanosecond_mode;
        logic [31:0] ts_seconds;
        logic [31:0] ts_nanoseconds;
        logic [31:0] captured_len;
        logic [31:0] original_len;
        logic [7:0]  payload_byte;
        logic        last_of_packet;
    } t_out_item;

    // Assemble a 32-bit word from four file-order bytes.
    function automatic logic [31:0] pack32(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic swap);
        return swap ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    // Assemble a 16-bit word from two file-order bytes.
    function automatic logic [15:0] pack16(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic swap);
        return swap ? {b0, b1} : {b1, b0};
    endfunction

    // Map the file link type to its DLT number.
    function automatic logic [31:0] map_link(input logic [31:0] n);
        logic [31:0] m;
        unique case (n)
            32'd101: m = 32'd12;
            32'd100: m = 32'd11;
            32'd102: m = 32'd15;
            32'd103: m = 32'd16;
            32'd106: m = 32'd19;
            default: m = n;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pcap_stream_deframer_unit.sv
`default_nettype none

// Classic capture-file stream deframer.
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per stream
// byte in file order, or one end-of-stream request. Output channel
// (o_out_valid / i_out_ready / o_out_item): at most one result per request:
// the file header, each packet header, each payload byte (last flagged), a
// clean end, or a numbered error.
// A result passes the input register, then the result register, before it
// shows on o_out_valid. Throughput is one request per clock while i_out_ready
// is high: the two registers sit around a single combinational parse step,
// whose longest path is the microsecond to nanosecond multiply.
// When the receiver stalls, the input register still takes one more request
// before o_in_ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) returns the parser to the global header,
// clears the format flags, the snapshot length and the sticky error. After
// an error or a clean end, further requests are accepted and give no result
// until the next reset.
module pcap_stream_deframer_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire pcapdf_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output pcapdf_pkg::t_out_item      o_out_item
);

    logic                  r_in_valid;
    pcapdf_pkg::t_in_item  r_in_item;
    logic                  r_out_valid;
    pcapdf_pkg::t_out_item r_out_item;
    logic                  w_advance;
    logic                  w_res_valid;
    pcapdf_pkg::t_out_item w_res;

    // The held request moves on when the result register is free or emptying.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    pcapdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_item      (r_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held request lost or changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("stalled result lost or changed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_advance)
        else $error("parser stepped over a pending result");

endmodule

`default_nettype wire

FILE: rtl/pcapdf_parser.sv
`default_nettype none

module pcapdf_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire pcapdf_pkg::t_in_item  i_item,
    output logic                       o_res_valid,
    output pcapdf_pkg::t_out_item      o_res
);

    localparam int unsigned IDX_W = pcapdf_pkg::HDR_IDX_W;
    localparam logic [IDX_W-1:0] GLOB_LAST = IDX_W'(pcapdf_pkg::GLOBAL_HDR_LEN - 1);
    localparam logic [IDX_W-1:0] REC_LAST  = IDX_W'(pcapdf_pkg::RECORD_HDR_LEN - 1);

    pcapdf_pkg::t_phase r_phase, n_phase;
    logic [IDX_W-1:0]   r_count, n_count;
    logic [7:0]         r_hdr [pcapdf_pkg::GLOBAL_HDR_LEN];
    logic               r_swap, n_swap;
    logic               r_nano, n_nano;
    logic [31:0]        r_snap, n_snap;
    logic [31:0]        r_rem, n_rem;
    logic               r_broken, n_broken;

    logic               w_hdr_wr;
    logic [31:0]        w_magic;
    logic               w_mswap;
    logic               w_mnano;
    logic               w_mok;
    logic [31:0]        w_gsnap;
    logic               w_ver_ok;
    logic [31:0]        w_link;
    logic [31:0]        w_sec;
    logic [31:0]        w_sub;
    logic [31:0]        w_sub_ns;
    logic [31:0]        w_incl;
    logic [31:0]        w_orig;
    logic [31:0]        w_rem_dec;
    logic [7:0]         b;

    assign b = i_item.data_byte;

    // Global header fields; the last byte of the header is the current one.
    always_comb begin
        w_magic = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
        w_mswap = (w_magic == pcapdf_pkg::MAGIC_SWAP_NS) ||
                  (w_magic == pcapdf_pkg::MAGIC_SWAP_US);
        w_mnano = (w_magic == pcapdf_pkg::MAGIC_SWAP_NS) ||
                  (w_magic == pcapdf_pkg::MAGIC_NAT_NS);
        w_mok   = w_mswap || w_mnano || (w_magic == pcapdf_pkg::MAGIC_NAT_US);
        w_gsnap = pcapdf_pkg::pack32(r_hdr[16], r_hdr[17], r_hdr[18], r_hdr[19], w_mswap);
        w_ver_ok = (pcapdf_pkg::pack16(r_hdr[4], r_hdr[5], w_mswap) ==
                    pcapdf_pkg::VER_REQ_HI) &&
                   (pcapdf_pkg::pack16(r_hdr[6], r_hdr[7], w_mswap) ==
                    pcapdf_pkg::VER_REQ_LO);
        w_link  = pcapdf_pkg::map_link(
                      pcapdf_pkg::pack32(r_hdr[20], r_hdr[21], r_hdr[22], b, w_mswap));
    end

    // Record header fields; the last byte of the header is the current one.
    always_comb begin
        w_sec  = pcapdf_pkg::pack32(r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3], r_swap);
        w_sub  = pcapdf_pkg::pack32(r_hdr[4], r_hdr[5], r_hdr[6], r_hdr[7], r_swap);
        w_incl = pcapdf_pkg::pack32(r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11], r_swap);
        w_orig = pcapdf_pkg::pack32(r_hdr[12], r_hdr[13], r_hdr[14], b, r_swap);
    end

    // Microseconds to nanoseconds, wrapping at 32 bits.
    assign w_sub_ns  = w_sub * pcapdf_pkg::NS_PER_US;
    assign w_rem_dec = r_rem - 32'd1;

    // Next state and result for the item being processed.
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_swap      = r_swap;
        n_nano      = r_nano;
        n_snap      = r_snap;
        n_rem       = r_rem;
        n_broken    = r_broken;
        w_hdr_wr    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_broken && r_phase != pcapdf_pkg::PH_DONE) begin
            if (i_item.kind == pcapdf_pkg::KIND_END) begin
                o_res_valid = 1'b1;
                unique case (r_phase)
                    pcapdf_pkg::PH_GLOBAL: begin
                        n_broken          = 1'b1;
                        o_res.result_kind = pcapdf_pkg::RK_ERROR;
                        o_res.error_code  = pcapdf_pkg::ERR_TRUNC_GLOB;
                    end
                    pcapdf_pkg::PH_PAYLOAD: begin
                        n_broken          = 1'b1;
                        o_res.result_kind = pcapdf_pkg::RK_ERROR;
                        o_res.error_code  = pcapdf_pkg::ERR_TRUNC_PAY;
                    end
                    default: begin
                        if (r_count != '0) begin
                            n_broken          = 1'b1;
                            o_res.result_kind = pcapdf_pkg::RK_ERROR;
                            o_res.error_code  = pcapdf_pkg::ERR_TRUNC_REC;
                        end else begin
                            n_phase           = pcapdf_pkg::PH_DONE;
                            o_res.result_kind = pcapdf_pkg::RK_END;
                        end
                    end
                endcase
            end else if (r_phase == pcapdf_pkg::PH_PAYLOAD) begin
                // Forward one payload byte.
                n_rem              = w_rem_dec;
                o_res_valid        = 1'b1;
                o_res.result_kind  = pcapdf_pkg::RK_PAYLOAD;
                o_res.payload_byte = b;
                if (w_rem_dec == '0) begin
                    o_res.last_of_packet = 1'b1;
                    n_phase              = pcapdf_pkg::PH_RECORD;
                end
            end else begin
                // Collect a header byte.
                w_hdr_wr = 1'b1;
                n_count  = r_count + 1'b1;
                if (r_phase == pcapdf_pkg::PH_GLOBAL && r_count == GLOB_LAST) begin
                    n_count     = '0;
                    o_res_valid = 1'b1;
                    if (!w_mok) begin
                        n_broken          = 1'b1;
                        o_res.result_kind = pcapdf_pkg::RK_ERROR;
                        o_res.error_code  = pcapdf_pkg::ERR_BAD_MAGIC;
                    end else begin
                        n_swap = w_mswap;
                        n_nano = w_mnano;
                        n_snap = w_gsnap;
                        if (!w_ver_ok) begin
                            n_broken          = 1'b1;
                            o_res.result_kind = pcapdf_pkg::RK_ERROR;
                            o_res.error_code  = pcapdf_pkg::ERR_BAD_VERSION;
                        end else begin
                            n_phase           = pcapdf_pkg::PH_RECORD;
                            o_res.result_kind = pcapdf_pkg::RK_FILE_HDR;
                            o_res.link_type   = w_link;
                        end
                    end
                end else if (r_phase == pcapdf_pkg::PH_RECORD && r_count == REC_LAST) begin
                    n_count     = '0;
                    o_res_valid = 1'b1;
                    if (w_incl > r_snap) begin
                        n_broken          = 1'b1;
                        o_res.result_kind = pcapdf_pkg::RK_ERROR;
                        o_res.error_code  = pcapdf_pkg::ERR_OVER_SNAP;
                    end else begin
                        o_res.result_kind    = pcapdf_pkg::RK_PKT_HDR;
                        o_res.ts_seconds     = w_sec;
                        o_res.ts_nanoseconds = r_nano ? w_sub : w_sub_ns;
                        o_res.captured_len   = w_incl;
                        o_res.original_len   = w_orig;
                        n_rem                = w_incl;
                        n_phase = (w_incl != '0) ? pcapdf_pkg::PH_PAYLOAD
                                                 : pcapdf_pkg::PH_RECORD;
                    end
                end
            end
        end

        // Every result carries the stream format as it stands after this item.
        o_res.snap_len        = n_snap;
        o_res.byte_swapped    = n_swap;
        o_res.nanosecond_mode = n_nano;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pcapdf_pkg::PH_GLOBAL;
            r_count  <= '0;
            r_swap   <= 1'b0;
            r_nano   <= 1'b0;
            r_snap   <= '0;
            r_rem    <= '0;
            r_broken <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_swap   <= n_swap;
            r_nano   <= n_nano;
            r_snap   <= n_snap;
            r_rem    <= n_rem;
            r_broken <= n_broken;
        end
    end

    // Header byte store.
    always_ff @(posedge i_clk) begin
        if (i_step && w_hdr_wr) begin
            r_hdr[r_count] <= b;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= GLOB_LAST)
        else $error("header byte count beyond global header");

    a_record_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcapdf_pkg::PH_RECORD) |-> (r_count <= REC_LAST))
        else $error("header byte count beyond record header");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcapdf_pkg::PH_PAYLOAD) |-> (r_rem != '0))
        else $error("payload phase with nothing left");

    a_broken_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_broken |=> r_broken)
        else $error("error state cleared without reset");

endmodule

`default_nettype wire

FILE: test/pcapdf_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, predicts every result from the
// accepted requests, and compares each delivered result with the oldest
// prediction still waiting.
module pcapdf_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire pcapdf_pkg::t_in_item  i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire pcapdf_pkg::t_out_item i_out_item,
    output int unsigned                o_fail_count = 0,
    output int unsigned                o_pending = 0
);

    // Parser state as this checker sees it.
    pcapdf_pkg::t_phase phase;
    logic [4:0]  hdr_cnt;
    logic [7:0]  hdr_buf [pcapdf_pkg::GLOBAL_HDR_LEN];
    logic        swapped;
    logic        nsec;
    logic [31:0] snaplen;
    logic [31:0] remaining;
    logic        broken;

    pcapdf_pkg::t_out_item results_due[$];
    int unsigned mismatches = 0;

    // Word and half-word from the header store, in the stream's byte order.
    function automatic logic [31:0] hdr_word(input int unsigned off);
        logic [7:0] b0, b1, b2, b3;
        b0 = hdr_buf[off];
        b1 = hdr_buf[off + 1];
        b2 = hdr_buf[off + 2];
        b3 = hdr_buf[off + 3];
        if (swapped) begin
            return {b0, b1, b2, b3};
        end
        return {b3, b2, b1, b0};
    endfunction

    function automatic logic [15:0] hdr_half(input int unsigned off);
        if (swapped) begin
            return {hdr_buf[off], hdr_buf[off + 1]};
        end
        return {hdr_buf[off + 1], hdr_buf[off]};
    endfunction

    // Link type numbers as they appear in the file, translated to DLT values.
    function automatic logic [31:0] dlt_of(input logic [31:0] n);
        case (n)
            32'd101: return 32'd12;
            32'd100: return 32'd11;
            32'd102: return 32'd15;
            32'd103: return 32'd16;
            32'd106: return 32'd19;
            default: return n;
        endcase
    endfunction

    // A result that carries only the kind, the error and the format state.
    function automatic pcapdf_pkg::t_out_item status_item(input logic [2:0] rk,
                                                          input logic [2:0] err);
        pcapdf_pkg::t_out_item r;
        r = '0;
        r.result_kind     = rk;
        r.error_code      = err;
        r.snap_len        = snaplen;
        r.byte_swapped    = swapped;
        r.nanosecond_mode = nsec;
        return r;
    endfunction

    // Advance the parser by one request and tell whether it yields a result.
    function automatic void parse_step(input pcapdf_pkg::t_in_item req, output logic produced,
                                       output pcapdf_pkg::t_out_item res);
        logic [31:0] magic;
        logic [31:0] cap;
        logic [31:0] sub;
        produced = 1'b0;
        res      = '0;
        if (broken || phase == pcapdf_pkg::PH_DONE) begin
            return;
        end

        // End of stream: clean only between records.
        if (req.kind == pcapdf_pkg::KIND_END) begin
            produced = 1'b1;
            if (phase == pcapdf_pkg::PH_GLOBAL) begin
                broken = 1'b1;
                res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_TRUNC_GLOB);
            end else if (phase == pcapdf_pkg::PH_PAYLOAD) begin
                broken = 1'b1;
                res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_TRUNC_PAY);
            end else if (hdr_cnt != 0) begin
                broken = 1'b1;
                res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_TRUNC_REC);
            end else begin
                phase = pcapdf_pkg::PH_DONE;
                res = status_item(pcapdf_pkg::RK_END, pcapdf_pkg::ERR_NONE);
            end
            return;
        end

        // Payload bytes pass straight through.
        if (phase == pcapdf_pkg::PH_PAYLOAD) begin
            remaining = remaining - 32'd1;
            produced = 1'b1;
            res = status_item(pcapdf_pkg::RK_PAYLOAD, pcapdf_pkg::ERR_NONE);
            res.payload_byte = req.data_byte;
            if (remaining == 0) begin
                res.last_of_packet = 1'b1;
                phase = pcapdf_pkg::PH_RECORD;
            end
            return;
        end

        hdr_buf[hdr_cnt] = req.data_byte;
        hdr_cnt = hdr_cnt + 5'd1;

        // Global header complete: magic, version, snapshot length, link type.
        if (phase == pcapdf_pkg::PH_GLOBAL) begin
            if (hdr_cnt < pcapdf_pkg::GLOBAL_HDR_LEN) begin
                return;
            end
            hdr_cnt = '0;
            produced = 1'b1;
            magic = {hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]};
            case (magic)
                pcapdf_pkg::MAGIC_SWAP_NS: begin
                    swapped = 1'b1;
                    nsec = 1'b1;
                end
                pcapdf_pkg::MAGIC_SWAP_US: swapped = 1'b1;
                pcapdf_pkg::MAGIC_NAT_NS: nsec = 1'b1;
                pcapdf_pkg::MAGIC_NAT_US: ;
                default: begin
                    broken = 1'b1;
                    res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_BAD_MAGIC);
                    return;
                end
            endcase
            snaplen = hdr_word(16);
            if (hdr_half(4) != pcapdf_pkg::VER_REQ_HI ||
                hdr_half(6) != pcapdf_pkg::VER_REQ_LO) begin
                broken = 1'b1;
                res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_BAD_VERSION);
                return;
            end
            phase = pcapdf_pkg::PH_RECORD;
            res = status_item(pcapdf_pkg::RK_FILE_HDR, pcapdf_pkg::ERR_NONE);
            res.link_type = dlt_of(hdr_word(20));
            return;
        end

        // Record header complete.
        if (hdr_cnt < pcapdf_pkg::RECORD_HDR_LEN) begin
            return;
        end
        hdr_cnt = '0;
        produced = 1'b1;
        cap = hdr_word(8);
        if (cap > snaplen) begin
            broken = 1'b1;
            res = status_item(pcapdf_pkg::RK_ERROR, pcapdf_pkg::ERR_OVER_SNAP);
            return;
        end
        sub = hdr_word(4);
        res = status_item(pcapdf_pkg::RK_PKT_HDR, pcapdf_pkg::ERR_NONE);
        res.ts_seconds     = hdr_word(0);
        res.ts_nanoseconds = nsec ? sub : sub * pcapdf_pkg::NS_PER_US;
        res.captured_len   = cap;
        res.original_len   = hdr_word(12);
        remaining = cap;
        phase = (cap != 0) ? pcapdf_pkg::PH_PAYLOAD : pcapdf_pkg::PH_RECORD;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin : watch
        logic                  produced;
        pcapdf_pkg::t_out_item want;
        if (!i_rst_n) begin
            phase     = pcapdf_pkg::PH_GLOBAL;
            hdr_cnt   = '0;
            swapped   = 1'b0;
            nsec      = 1'b0;
            snaplen   = '0;
            remaining = '0;
            broken    = 1'b0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result of kind %0d arrived with no result expected",
                           i_out_item.result_kind);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", 32'(want.result_kind),
                                32'(i_out_item.result_kind));
                    check_field("error_code", 32'(want.error_code),
                                32'(i_out_item.error_code));
                    check_field("link_type", want.link_type, i_out_item.link_type);
                    check_field("snap_len", want.snap_len, i_out_item.snap_len);
                    check_field("byte_swapped", 32'(want.byte_swapped),
                                32'(i_out_item.byte_swapped));
                    check_field("nanosecond_mode", 32'(want.nanosecond_mode),
                                32'(i_out_item.nanosecond_mode));
                    check_field("ts_seconds", want.ts_seconds, i_out_item.ts_seconds);
                    check_field("ts_nanoseconds", want.ts_nanoseconds,
                                i_out_item.ts_nanoseconds);
                    check_field("captured_len", want.captured_len, i_out_item.captured_len);
                    check_field("original_len", want.original_len, i_out_item.original_len);
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_out_item.payload_byte));
                    check_field("last_of_packet", 32'(want.last_of_packet),
                                32'(i_out_item.last_of_packet));
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_step(i_in_item, produced, want);
                if (produced) begin
                    results_due.push_back(want);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned ITEM_TARGET  = 550;
    localparam int unsigned NOISE_ITEMS  = 20;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_CAP      = 24;

    // How the stream is brought to its end; only one ending per reset.
    typedef enum int {
        ENDS_CLEAN,
        ENDS_MID_HEADER,
        ENDS_MID_PAYLOAD,
        ENDS_OVERSIZE,
        ENDS_BAD_MAGIC,
        ENDS_BAD_VERSION,
        ENDS_SHORT_GLOBAL
    } t_ending;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    pcapdf_pkg::t_in_item  i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    pcapdf_pkg::t_out_item o_out_item;
    int unsigned           fail_count;
    int unsigned           pending;

    int unsigned sent_items = 0;
    logic        in_calm = 1'b0;
    logic        out_calm = 1'b0;

    pcap_stream_deframer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    pcapdf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones and a rare long one; none in calm stretches.
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random 32-bit value with its extremes given extra weight.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Captured length that fits the snapshot length and keeps packets short.
    function automatic logic [31:0] pick_cap(input logic [31:0] snap);
        logic [31:0] ceiling;
        ceiling = (snap < MAX_CAP) ? snap : MAX_CAP;
        if (ceiling == 0 || $urandom_range(0, 5) == 0) begin
            return '0;
        end
        if (ceiling == snap && $urandom_range(0, 3) == 0) begin
            return ceiling;
        end
        return $urandom_range(1, ceiling);
    endfunction

    function automatic logic is_magic(input logic [31:0] m);
        return m == pcapdf_pkg::MAGIC_SWAP_NS || m == pcapdf_pkg::MAGIC_SWAP_US
            || m == pcapdf_pkg::MAGIC_NAT_US || m == pcapdf_pkg::MAGIC_NAT_NS;
    endfunction

    function automatic logic [31:0] pick_magic();
        case ($urandom_range(0, 3))
            0: return pcapdf_pkg::MAGIC_SWAP_NS;
            1: return pcapdf_pkg::MAGIC_SWAP_US;
            2: return pcapdf_pkg::MAGIC_NAT_NS;
            default: return pcapdf_pkg::MAGIC_NAT_US;
        endcase
    endfunction

    function automatic logic [31:0] pick_link();
        case ($urandom_range(0, 9))
            0: return 32'd101;
            1: return 32'd100;
            2: return 32'd102;
            3: return 32'd103;
            4: return 32'd104;
            5: return 32'd106;
            6: return 32'd50;
            7: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_snap();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end else if (r < 5) begin
            return '1;
        end else if (r < 8) begin
            return $urandom | 32'h8000_0000;
        end
        return $urandom_range(1, 40);
    endfunction

    // One request on the input channel, after an optional gap.
    // Called and returning at a falling edge.
    task automatic push_req(input logic req_kind, input logic [7:0] b);
        int unsigned idle;
        if (sent_items % 64 == 0) begin
            in_calm = ($urandom_range(0, 3) == 0);
        end
        idle = pick_gap(in_calm);
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= {req_kind, b};
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic push_word(input logic [31:0] w, input logic sw);
        if (sw) begin
            push_req(pcapdf_pkg::KIND_BYTE, w[31:24]);
            push_req(pcapdf_pkg::KIND_BYTE, w[23:16]);
            push_req(pcapdf_pkg::KIND_BYTE, w[15:8]);
            push_req(pcapdf_pkg::KIND_BYTE, w[7:0]);
        end else begin
            push_req(pcapdf_pkg::KIND_BYTE, w[7:0]);
            push_req(pcapdf_pkg::KIND_BYTE, w[15:8]);
            push_req(pcapdf_pkg::KIND_BYTE, w[23:16]);
            push_req(pcapdf_pkg::KIND_BYTE, w[31:24]);
        end
    endtask

    task automatic push_half(input logic [15:0] h, input logic sw);
        if (sw) begin
            push_req(pcapdf_pkg::KIND_BYTE, h[15:8]);
            push_req(pcapdf_pkg::KIND_BYTE, h[7:0]);
        end else begin
            push_req(pcapdf_pkg::KIND_BYTE, h[7:0]);
            push_req(pcapdf_pkg::KIND_BYTE, h[15:8]);
        end
    endtask

    // The magic always goes out in its little-endian form; it sets the order
    // of every field after it.
    task automatic push_global(input logic [31:0] magic, input logic [15:0] maj,
                               input logic [15:0] mnr, input logic [31:0] snap,
                               input logic sw);
        push_word(magic, 1'b0);
        push_half(maj, sw);
        push_half(mnr, sw);
        push_word($urandom, sw);
        push_word($urandom, sw);
        push_word(snap, sw);
        push_word(pick_link(), sw);
    endtask

    task automatic push_record_hdr(input logic [31:0] cap, input logic sw);
        logic [31:0] orig;
        case ($urandom_range(0, 2))
            0: orig = cap;
            1: orig = cap + $urandom_range(1, 1500);
            default: orig = pick_word();
        endcase
        push_word(pick_word(), sw);
        push_word(pick_word(), sw);
        push_word(cap, sw);
        push_word(orig, sw);
    endtask

    task automatic push_bytes(input int unsigned count);
        repeat (count) push_req(pcapdf_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Output side stalls on its own schedule.
    initial begin : sink_pacing
        int unsigned hold;
        int unsigned tick;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 80 == 0) begin
                out_calm = ($urandom_range(0, 3) == 0);
            end
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                hold = pick_gap(out_calm);
            end
        end
    end

    // Stimulus: one capture stream per run, ended in a way picked at random.
    initial begin : stimulus
        t_ending     ending;
        logic [31:0] magic;
        logic [31:0] snap;
        logic [31:0] cap;
        logic [15:0] maj;
        logic [15:0] mnr;
        logic        sw;
        int unsigned r;
        int unsigned noise_left;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        r = $urandom_range(0, 19);
        if (r == 0) begin
            ending = ENDS_BAD_MAGIC;
        end else if (r == 1) begin
            ending = ENDS_BAD_VERSION;
        end else if (r == 2) begin
            ending = ENDS_SHORT_GLOBAL;
        end else if (r < 6) begin
            ending = ENDS_MID_HEADER;
        end else if (r < 9) begin
            ending = ENDS_MID_PAYLOAD;
        end else if (r < 12) begin
            ending = ENDS_OVERSIZE;
        end else begin
            ending = ENDS_CLEAN;
        end

        magic = pick_magic();
        sw    = (magic == pcapdf_pkg::MAGIC_SWAP_NS || magic == pcapdf_pkg::MAGIC_SWAP_US);
        snap  = pick_snap();

        case (ending)
            ENDS_BAD_MAGIC: begin
                // Either a near miss of a real magic or anything at all.
                do begin
                    if ($urandom_range(0, 1) == 0) begin
                        magic = pick_magic() ^ (32'd1 << $urandom_range(0, 31));
                    end else begin
                        magic = $urandom;
                    end
                end while (is_magic(magic));
                push_global(magic, pcapdf_pkg::VER_REQ_HI, pcapdf_pkg::VER_REQ_LO, snap, sw);
            end
            ENDS_BAD_VERSION: begin
                do begin
                    maj = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 5));
                    mnr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 5));
                end while (maj == pcapdf_pkg::VER_REQ_HI && mnr == pcapdf_pkg::VER_REQ_LO);
                push_global(magic, maj, mnr, snap, sw);
            end
            ENDS_SHORT_GLOBAL: begin
                // Sometimes the stream ends before its first byte.
                if ($urandom_range(0, 3) != 0) begin
                    push_bytes($urandom_range(1, pcapdf_pkg::GLOBAL_HDR_LEN - 1));
                end
                push_req(pcapdf_pkg::KIND_END, 8'($urandom_range(0, 255)));
            end
            default: begin
                push_global(magic, pcapdf_pkg::VER_REQ_HI, pcapdf_pkg::VER_REQ_LO, snap, sw);
                // An empty record right after the file header.
                push_word('0, sw);
                push_word('0, sw);
                push_word('0, sw);
                push_word('0, sw);
                while (sent_items < ITEM_TARGET) begin
                    cap = pick_cap(snap);
                    push_record_hdr(cap, sw);
                    push_bytes(cap);
                end
                if (ending == ENDS_MID_PAYLOAD && snap == 0) begin
                    ending = ENDS_MID_HEADER;
                end
                if (ending == ENDS_OVERSIZE && snap == '1) begin
                    ending = ENDS_CLEAN;
                end
                case (ending)
                    ENDS_MID_HEADER: begin
                        push_bytes($urandom_range(1, pcapdf_pkg::RECORD_HDR_LEN - 1));
                        push_req(pcapdf_pkg::KIND_END, 8'($urandom_range(0, 255)));
                    end
                    ENDS_MID_PAYLOAD: begin
                        cap = $urandom_range(1, (snap < MAX_CAP) ? snap : MAX_CAP);
                        push_record_hdr(cap, sw);
                        push_bytes($urandom_range(0, cap - 1));
                        push_req(pcapdf_pkg::KIND_END, 8'($urandom_range(0, 255)));
                    end
                    ENDS_OVERSIZE: begin
                        cap = $urandom;
                        if (cap <= snap || $urandom_range(0, 1) == 0) begin
                            cap = snap + 32'd1;
                        end
                        push_record_hdr(cap, sw);
                    end
                    default: push_req(pcapdf_pkg::KIND_END, 8'($urandom_range(0, 255)));
                endcase
            end
        endcase

        // Whatever follows an error or a clean end must be swallowed; short
        // streams are topped up so that every run sends about the same count.
        noise_left = NOISE_ITEMS;
        while (noise_left != 0 || sent_items < ITEM_TARGET) begin
            push_req(($urandom_range(0, 3) == 0) ? pcapdf_pkg::KIND_END
                                                 : pcapdf_pkg::KIND_BYTE,
                     8'($urandom_range(0, 255)));
            if (noise_left != 0) begin
                noise_left--;
            end
        end
        i_in_valid <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS pcap_stream_deframer_unit");
        end else begin
            $display("FAIL pcap_stream_deframer_unit");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #2_000_000;
        $display("FAIL pcap_stream_deframer_unit");
        $finish;
    end

endmodule
